// ----- rtl/nd_strided_address_generator_macros.svh -----
// Assertion macros shared by the checkers of the address generator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ND_STRIDED_ADDRESS_GENERATOR_MACROS_SVH
`define ND_STRIDED_ADDRESS_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSAG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define NSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

// ----- rtl/nsag_pkg.sv -----
// Shared types and constants of the strided address generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package nsag_pkg;

	localparam int OP_W        = 3;
	localparam int AMOUNT_W    = 32;
	localparam int STRIDE_W    = 32;
	localparam int NUM_STRIDES = 4;
	localparam int OFFSET_W    = 50;
	localparam int OUT_COORD_W = 16;
	localparam int NUM_OUT     = 4;
	localparam int AXIS_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
	localparam logic [OP_W-1:0] OP_STEP  = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
	localparam logic [OP_W-1:0] OP_LINE  = 3'd3;
	localparam logic [OP_W-1:0] OP_PLANE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_3    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BCAST       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AXIS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_AXIS = 3'd7;

	localparam logic [CFG_DATA_W-1:0] DIM_SIZES_RST   = 64'h0001_0001_0001_0001;
	localparam logic [AXIS_W-1:0]     FIRST_AXIS_RST  = 2'd0;
	localparam logic [AXIS_W-1:0]     SECOND_AXIS_RST = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic div_start;
		logic div_commit;
		logic step;
		logic mul;
		logic acc;
		logic out_load;
	} nsag_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic div_done;
		logic step_stop;
		logic out_free;
	} nsag_stat_t;

endpackage

`default_nettype wire

// ----- rtl/nsag_div.sv -----
// Restoring divider, one quotient bit per cycle, for the digit split.
// Uses nsag_pkg; instantiated by nsag_dp.
`default_nettype none

module nsag_div
	import nsag_pkg::*;
#(
	parameter int DIVIDEND_W = 35,
	parameter int DIVISOR_W  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [DIVISOR_W-1:0]  divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient,
	output logic [DIVISOR_W-1:0]       remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    partial;
	logic                  ge;
	logic [DIVISOR_W:0]    diff;

	assign partial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge      = partial >= {1'b0, dsr_q};
	assign diff    = partial - {1'b0, dsr_q};

	assign done      = busy_q && (cnt_q == '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			// shift in one dividend bit, subtract when it fits
			rem_q <= ge ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/nsag_ctrl.sv -----
// Controller of the address generator: sequences digit division, carry
// steps and the offset sum per dimension. Uses nsag_pkg.
`default_nettype none

module nsag_ctrl
	import nsag_pkg::*;
#(
	parameter int NUM_DIMS = 4,
	parameter int DIM_W    = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [OP_W-1:0] op,
	input  wire nsag_stat_t      stat,
	output nsag_cmd_t            cmd,
	output logic [DIM_W-1:0]     dim
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_STEP,
		S_MUL,
		S_ACC,
		S_OUT
	} state_t;

	localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(NUM_DIMS - 1);

	state_t           state_q;
	logic [DIM_W-1:0] dim_q;

	assign dim = dim_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_DIV_GO:   cmd.div_start  = 1'b1;
			S_DIV_WAIT: cmd.div_commit = stat.div_done;
			S_STEP:     cmd.step       = 1'b1;
			S_MUL:      cmd.mul        = 1'b1;
			S_ACC:      cmd.acc        = 1'b1;
			S_OUT:      cmd.out_load   = stat.out_free;
			default:    cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dim_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dim_q <= '0;
						case (op)
							OP_LOAD, OP_ADD:           state_q <= S_DIV_GO;
							OP_STEP, OP_LINE, OP_PLANE: state_q <= S_STEP;
							default:                   state_q <= S_MUL;
						endcase
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						if (dim_q == LAST_DIM) begin
							dim_q   <= '0;
							state_q <= S_MUL;
						end else begin
							dim_q   <= dim_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_STEP: begin
					// stop at the first digit that absorbs the carry
					if (stat.step_stop || (dim_q == LAST_DIM)) begin
						dim_q   <= '0;
						state_q <= S_MUL;
					end else begin
						dim_q <= dim_q + 1'b1;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (dim_q == LAST_DIM) begin
						state_q <= S_OUT;
					end else begin
						dim_q   <= dim_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/nsag_dp.sv -----
// Datapath of the address generator: configuration registers, coordinate
// digits, divider, multiply-accumulate and output register. Uses nsag_pkg, nsag_div.
`default_nettype none

module nsag_dp
	import nsag_pkg::*;
#(
	parameter int NUM_DIMS   = 4,
	parameter int COORD_BITS = 16,
	parameter int DIM_W      = 2
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire nsag_cmd_t              cmd,
	input  wire logic [DIM_W-1:0]       dim,
	output nsag_stat_t                  stat,
	input  wire logic [OP_W-1:0]        op,
	input  wire logic [AMOUNT_W-1:0]    amount,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_COORD_W-1:0]      coord_0,
	output logic [OUT_COORD_W-1:0]      coord_1,
	output logic [OUT_COORD_W-1:0]      coord_2,
	output logic [OUT_COORD_W-1:0]      coord_3,
	output logic [OFFSET_W-1:0]         bit_offset
);

	localparam int WIDE_W = (AMOUNT_W > COORD_BITS) ? AMOUNT_W : COORD_BITS;
	localparam int DIV_W  = WIDE_W + $clog2(NUM_DIMS + 1);
	localparam int SZ_W   = NUM_DIMS * COORD_BITS + CFG_DATA_W;
	localparam int PROD_W = COORD_BITS + STRIDE_W;

	// configuration
	logic [CFG_DATA_W-1:0] dim_sizes_q;
	logic [STRIDE_W-1:0]   stride_q [NUM_STRIDES];
	logic [NUM_STRIDES-1:0] bcast_q;
	logic [AXIS_W-1:0]     first_axis_q;
	logic [AXIS_W-1:0]     second_axis_q;

	// coordinate and work registers
	logic [COORD_BITS-1:0] pos_q [NUM_DIMS];
	logic [OP_W-1:0]       op_q;
	logic [DIV_W-1:0]      carry_q;
	logic [PROD_W-1:0]     prod_q;
	logic [OFFSET_W-1:0]   acc_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_COORD_W-1:0] out_coord_q [NUM_OUT];
	logic [OUT_COORD_W-1:0] out_coord_d [NUM_OUT];
	logic [OFFSET_W-1:0]    out_offset_q;

	logic [SZ_W-1:0]       sizes_ext;
	logic [COORD_BITS-1:0] size_d   [NUM_DIMS];
	logic [STRIDE_W-1:0]   stride_d [NUM_DIMS];
	logic [NUM_DIMS-1:0]   skip_d;

	logic [COORD_BITS-1:0] cur_pos;
	logic [COORD_BITS-1:0] cur_size;
	logic [STRIDE_W-1:0]   cur_stride;
	logic                  cur_skip;
	logic [COORD_BITS:0]   incr;
	logic                  step_stop;

	logic                  div_done;
	logic [DIV_W-1:0]      div_quo;
	logic [COORD_BITS-1:0] div_rem;

	assign sizes_ext = SZ_W'(dim_sizes_q);

	for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
		logic [COORD_BITS-1:0] raw;
		assign raw       = sizes_ext[d*COORD_BITS +: COORD_BITS];
		// a size of zero counts as one
		assign size_d[d] = (raw == '0) ? COORD_BITS'(1) : raw;
		assign skip_d[d] = ((op_q == OP_LINE) || (op_q == OP_PLANE)) && (int'(first_axis_q) == d)
			|| (op_q == OP_PLANE) && (int'(second_axis_q) == d);
		if (d < NUM_STRIDES) begin : g_str
			assign stride_d[d] = bcast_q[d] ? '0 : stride_q[d];
		end else begin : g_nostr
			assign stride_d[d] = '0;
		end
	end

	for (genvar k = 0; k < NUM_OUT; k++) begin : g_out
		if (k < NUM_DIMS) begin : g_live
			assign out_coord_d[k] = OUT_COORD_W'(pos_q[k]);
		end else begin : g_dead
			assign out_coord_d[k] = '0;
		end
	end

	assign cur_pos    = pos_q[dim];
	assign cur_size   = size_d[dim];
	assign cur_stride = stride_d[dim];
	assign cur_skip   = skip_d[dim];
	assign incr       = {1'b0, cur_pos} + 1'b1;
	assign step_stop  = !cur_skip && (incr < {1'b0, cur_size});

	nsag_div #(
		.DIVIDEND_W(DIV_W),
		.DIVISOR_W (COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (carry_q + DIV_W'(cur_pos)),
		.divisor  (cur_size),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign stat.div_done  = div_done;
	assign stat.step_stop = step_stop;
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_sizes_q   <= DIM_SIZES_RST;
			for (int i = 0; i < NUM_STRIDES; i++) begin
				stride_q[i] <= '0;
			end
			bcast_q       <= '0;
			first_axis_q  <= FIRST_AXIS_RST;
			second_axis_q <= SECOND_AXIS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIM_SIZES:   dim_sizes_q   <= cfg_data;
				CFG_STRIDE_0:    stride_q[0]   <= cfg_data[STRIDE_W-1:0];
				CFG_STRIDE_1:    stride_q[1]   <= cfg_data[STRIDE_W-1:0];
				CFG_STRIDE_2:    stride_q[2]   <= cfg_data[STRIDE_W-1:0];
				CFG_STRIDE_3:    stride_q[3]   <= cfg_data[STRIDE_W-1:0];
				CFG_BCAST:       bcast_q       <= cfg_data[NUM_STRIDES-1:0];
				CFG_FIRST_AXIS:  first_axis_q  <= cfg_data[AXIS_W-1:0];
				CFG_SECOND_AXIS: second_axis_q <= cfg_data[AXIS_W-1:0];
				default:         dim_sizes_q   <= dim_sizes_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				pos_q[i] <= '0;
			end
		end else if (cmd.take && (op == OP_LOAD)) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				pos_q[i] <= '0;
			end
		end else if (cmd.div_commit) begin
			pos_q[dim] <= div_rem;
		end else if (cmd.step && !cur_skip) begin
			// digit at its end (or past it) wraps and passes the carry on
			pos_q[dim] <= step_stop ? incr[COORD_BITS-1:0] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= op;
			carry_q <= DIV_W'(amount);
			acc_q   <= '0;
		end else begin
			if (cmd.div_commit) begin
				carry_q <= div_quo;
			end
			if (cmd.mul) begin
				prod_q <= PROD_W'(cur_pos) * PROD_W'(cur_stride);
			end
			if (cmd.acc) begin
				acc_q <= acc_q + OFFSET_W'(prod_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_coord_q  <= out_coord_d;
			out_offset_q <= acc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign coord_0    = out_coord_q[0];
	assign coord_1    = out_coord_q[1];
	assign coord_2    = out_coord_q[2];
	assign coord_3    = out_coord_q[3];
	assign bit_offset = out_offset_q;

endmodule

`default_nettype wire

// ----- rtl/nd_strided_address_generator.sv -----
// N-dimensional strided address generator. Keeps a mixed-radix coordinate
// and returns it with its strided bit offset for every word accepted. One
// word is in flight at a time; the result sits in an output register, so
// the next word is taken while the previous result waits. Load and add,
// with N = NUM_DIMS and W = max(32, COORD_BITS) + clog2(N + 1) dividend
// bits, split each digit through the shared restoring divider, one
// quotient bit per cycle; step, next line and next plane walk the digits
// from the lowest, 1 to N of them, until one absorbs the carry; other ops
// go straight to the offset sum. The offset is summed one dimension at a
// time through a single multiplier, each product registered before it is
// accumulated. Configuration writes are taken every cycle and must only
// arrive while the block is idle. Uses nsag_pkg, nsag_ctrl, nsag_dp.
`default_nettype none

module nd_strided_address_generator
	import nsag_pkg::*;
#(
	parameter int NUM_DIMS   = 4,
	parameter int COORD_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [OP_W-1:0]        op,
	input  wire logic [AMOUNT_W-1:0]    amount,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_COORD_W-1:0]      coord_0,
	output logic [OUT_COORD_W-1:0]      coord_1,
	output logic [OUT_COORD_W-1:0]      coord_2,
	output logic [OUT_COORD_W-1:0]      coord_3,
	output logic [OFFSET_W-1:0]         bit_offset,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int DIM_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

	nsag_cmd_t        cmd;
	nsag_stat_t       stat;
	logic [DIM_W-1:0] dim;

	assign cfg_ready = 1'b1;

	nsag_ctrl #(
		.NUM_DIMS(NUM_DIMS),
		.DIM_W   (DIM_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op      (op),
		.stat    (stat),
		.cmd     (cmd),
		.dim     (dim)
	);

	nsag_dp #(
		.NUM_DIMS  (NUM_DIMS),
		.COORD_BITS(COORD_BITS),
		.DIM_W     (DIM_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.dim       (dim),
		.stat      (stat),
		.op        (op),
		.amount    (amount),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.coord_0   (coord_0),
		.coord_1   (coord_1),
		.coord_2   (coord_2),
		.coord_3   (coord_3),
		.bit_offset(bit_offset)
	);

endmodule

`default_nettype wire

// ----- rtl/nsag_checker.sv -----
// Port-level checker of the address generator and its bind to the top.
// Uses nsag_pkg and nd_strided_address_generator_macros.svh.
`default_nettype none

`include "nd_strided_address_generator_macros.svh"

module nsag_checker
	import nsag_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [OUT_COORD_W-1:0] coord_0,
	input wire logic [OFFSET_W-1:0]    bit_offset
);

	// a stalled result word holds
	`NSAG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(bit_offset) && $stable(coord_0))

	// one word in flight: intake closes right after an accept
	`NSAG_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// an idle block stays open
	`NSAG_ASSERT_NEXT(a_idle_stays, clk, arst_n, in_ready && !in_valid, in_ready)

	// a new result only comes out of a busy block
	`NSAG_ASSERT_IMPL(a_result_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind nd_strided_address_generator nsag_checker u_nsag_checker (.*);

`default_nettype wire
